### rtl/set_assoc_tlb_lru_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef SET_ASSOC_TLB_LRU_DEFINES_SVH
`define SET_ASSOC_TLB_LRU_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define STLRU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define STLRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stlru_pkg.sv
package stlru_pkg;

    localparam int CMD_W   = 2;
    localparam int VADDR_W = 48;
    localparam int FRAME_W = 36;
    localparam int PADDR_W = 48;
    localparam int RANK_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_XLATE = 2'd0,
        CMD_PEEK  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // Request to the LRU row store
    typedef struct packed {
        logic rd;
        logic touch;
        logic fill;
        logic clr;
    } t_lru_req;

endpackage

### rtl/stlru_in_if.sv
interface stlru_in_if;
    import stlru_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [VADDR_W-1:0] vaddr;
    logic               walk_fault;
    logic [FRAME_W-1:0] walk_frame;

    modport source (output valid, output cmd, output vaddr, output walk_fault,
                    output walk_frame, input ready);
    modport sink   (input valid, input cmd, input vaddr, input walk_fault,
                    input walk_frame, output ready);
endinterface

### rtl/stlru_out_if.sv
interface stlru_out_if;
    import stlru_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic               fault;
    logic [PADDR_W-1:0] paddr;
    logic [RANK_W-1:0]  rank;

    modport source (output valid, output hit, output fault, output paddr, output rank,
                    input ready);
    modport sink   (input valid, input hit, input fault, input paddr, input rank,
                    output ready);
endinterface

### rtl/stlru_div.sv
// Split the page number into set index and tag. The set count must be a power of
// two, unchecked here, so the set index is the low page bits and the tag the rest.
module stlru_div #(
    parameter int PAGE_BITS = 36,
    parameter int NUM_SETS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [PAGE_BITS-1:0] i_page,
    output logic                 o_done,
    output logic [PAGE_BITS-1:0] o_quot,
    output logic [((NUM_SETS > 1) ? $clog2(NUM_SETS) : 1)-1:0] o_rem
);
    localparam int REM_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SET_LOG = $clog2(NUM_SETS);

    logic                 r_done;
    logic [PAGE_BITS-1:0] r_quot;
    logic [REM_W-1:0]     r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_quot <= i_page >> SET_LOG;
                r_rem  <= (NUM_SETS > 1) ? REM_W'(i_page) : '0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

### rtl/stlru_lru.sv
// Per-set valid bits and LRU ranks, with promotion, fill, clear and victim choice.
module stlru_lru import stlru_pkg::*; #(
    parameter int NUM_SETS = 16,
    parameter int NUM_WAYS = 4
) (
    input  logic     i_clk,
    input  t_lru_req i_req,
    input  logic [((NUM_SETS > 1) ? $clog2(NUM_SETS) : 1)-1:0] i_set,
    input  logic [$clog2(NUM_WAYS)-1:0] i_way,
    output logic                        o_valid,
    output logic [$clog2(NUM_WAYS)-1:0] o_rank,
    output logic [$clog2(NUM_WAYS)-1:0] o_victim
);
    localparam int WAY_BITS = $clog2(NUM_WAYS);

    logic [NUM_WAYS-1:0]                mem_vld  [NUM_SETS];
    logic [NUM_WAYS-1:0][WAY_BITS-1:0]  mem_rank [NUM_SETS];

    logic [NUM_WAYS-1:0]                r_vld_q;
    logic [NUM_WAYS-1:0][WAY_BITS-1:0]  r_rank_q;

    logic [NUM_WAYS-1:0][WAY_BITS-1:0]  w_prom;
    logic [NUM_WAYS-1:0][WAY_BITS-1:0]  w_init;
    logic [NUM_WAYS-1:0]                w_sel;
    logic [WAY_BITS-1:0]                w_old;

    always_comb begin
        w_old = r_rank_q[i_way];
        w_sel = NUM_WAYS'(1) << i_way;
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_init[w] = WAY_BITS'(w);
            if (WAY_BITS'(w) == i_way) begin
                w_prom[w] = '0;
            end else if (r_rank_q[w] < w_old) begin
                w_prom[w] = r_rank_q[w] + 1'b1;
            end else begin
                w_prom[w] = r_rank_q[w];
            end
        end
    end

    // lowest invalid way first, else the least recent one
    always_comb begin
        logic found;
        found    = 1'b0;
        o_victim = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!found && !r_vld_q[w]) begin
                o_victim = WAY_BITS'(w);
                found    = 1'b1;
            end
        end
        if (!found) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (r_rank_q[w] == WAY_BITS'(NUM_WAYS - 1)) begin
                    o_victim = WAY_BITS'(w);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.clr) begin
            mem_vld[i_set]  <= '0;
            mem_rank[i_set] <= w_init;
        end else if (i_req.fill) begin
            mem_vld[i_set]  <= r_vld_q | w_sel;
            mem_rank[i_set] <= w_prom;
        end else if (i_req.touch) begin
            mem_rank[i_set] <= w_prom;
        end
        if (i_req.rd) begin
            r_vld_q  <= mem_vld[i_set];
            r_rank_q <= mem_rank[i_set];
        end
    end

    assign o_valid = r_vld_q[i_way];
    assign o_rank  = r_rank_q[i_way];

endmodule

### rtl/set_assoc_tlb_lru.sv
// Set-associative translation buffer, NUM_SETS sets by NUM_WAYS ways, true LRU per set.
// NUM_SETS must be a power of two: the set index is the low page bits, the tag the rest.
// One item at a time. Translate and peek go from acceptance to the result in these steps:
// split the page number, read the set's LRU row, read and compare each way in turn
// through the single tag port until a match or the last way, update, and load the
// output register. Clear sweeps the LRU rows, one LRU row per cycle, and the unused
// command goes straight to the output register. The input is ready again the cycle after the
// result is loaded; loading waits while the output register still holds an unaccepted
// result. After reset the block sweeps the LRU rows before it takes its first item.
// A finished result sits in an output register, so the next item is accepted while it waits.
`include "set_assoc_tlb_lru_defines.svh"

module set_assoc_tlb_lru import stlru_pkg::*; #(
    parameter int OFFSET_BITS = 12,
    parameter int NUM_SETS    = 16,
    parameter int NUM_WAYS    = 4,
    parameter int VA_BITS     = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stlru_in_if.sink    i_in,
    stlru_out_if.source o_out
);
    localparam int VA_EFF    = (VA_BITS < VADDR_W) ? VA_BITS : VADDR_W;
    localparam int PAGE_BITS = VA_EFF - OFFSET_BITS;
    localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_BITS  = $clog2(NUM_WAYS);
    localparam int TAG_RAW   = PAGE_BITS - $clog2(NUM_SETS + 1) + 1;
    localparam int TAG_BITS  = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int ADDR_W    = SET_BITS + WAY_BITS;
    localparam int DEPTH     = 1 << ADDR_W;

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_DIV, S_ROW, S_RD, S_CMP, S_UPD, S_OUT
    } t_state;

    t_state                 r_state;
    logic [SET_BITS-1:0]    r_sweep;
    logic                   r_reply;
    logic [CMD_W-1:0]       r_cmd;
    logic [OFFSET_BITS-1:0] r_off;
    logic                   r_walk_fault;
    logic [FRAME_W-1:0]     r_walk_frame;
    logic [WAY_BITS-1:0]    r_way;
    logic                   r_hit;
    logic [FRAME_W-1:0]     r_hit_frame;
    logic                   r_res_hit;
    logic                   r_res_fault;
    logic [PADDR_W-1:0]     r_res_paddr;
    logic [RANK_W-1:0]      r_res_rank;
    logic                   r_out_valid;
    logic                   r_out_hit;
    logic                   r_out_fault;
    logic [PADDR_W-1:0]     r_out_paddr;
    logic [RANK_W-1:0]      r_out_rank;

    logic [TAG_BITS-1:0]    mem_tag   [DEPTH];
    logic [FRAME_W-1:0]     mem_frame [DEPTH];
    logic [TAG_BITS-1:0]    r_tag_q;
    logic [FRAME_W-1:0]     r_frame_q;

    logic                   w_div_start;
    logic                   w_div_done;
    logic [PAGE_BITS-1:0]   w_quot;
    logic [SET_BITS-1:0]    w_set;
    logic [TAG_BITS-1:0]    w_tag;

    t_lru_req               w_lru_req;
    logic [SET_BITS-1:0]    w_lru_set;
    logic [WAY_BITS-1:0]    w_lru_way;
    logic                   w_lru_valid;
    logic [WAY_BITS-1:0]    w_lru_rank;
    logic [WAY_BITS-1:0]    w_victim;

    logic                   w_match;
    logic [FRAME_W-1:0]     w_join_frame;
    logic [FRAME_W+OFFSET_BITS+PADDR_W-1:0] w_join_ext;
    logic [PADDR_W-1:0]     w_join;
    logic [WAY_BITS+RANK_W:0] w_rank_ext;

    stlru_div #(
        .PAGE_BITS (PAGE_BITS),
        .NUM_SETS  (NUM_SETS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_page  (i_in.vaddr[VA_EFF-1:OFFSET_BITS]),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_rem   (w_set)
    );

    stlru_lru #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS)
    ) u_lru (
        .i_clk    (i_clk),
        .i_req    (w_lru_req),
        .i_set    (w_lru_set),
        .i_way    (w_lru_way),
        .o_valid  (w_lru_valid),
        .o_rank   (w_lru_rank),
        .o_victim (w_victim)
    );

    assign w_tag = w_quot[TAG_BITS-1:0];

    always_comb begin
        w_div_start = (r_state == S_IDLE) && i_in.valid &&
                      (i_in.cmd == CMD_XLATE || i_in.cmd == CMD_PEEK);
        w_lru_req.rd    = (r_state == S_ROW);
        w_lru_req.clr   = (r_state == S_SWEEP);
        w_lru_req.touch = (r_state == S_UPD) && (r_cmd == CMD_XLATE) && r_hit;
        w_lru_req.fill  = (r_state == S_UPD) && (r_cmd == CMD_XLATE) && !r_hit &&
                          !r_walk_fault;
        w_lru_set = (r_state == S_SWEEP) ? r_sweep : w_set;
        w_lru_way = w_lru_req.fill ? w_victim : r_way;

        w_match      = w_lru_valid && (r_tag_q == w_tag);
        w_join_frame = r_hit ? r_hit_frame : r_walk_frame;
        w_join_ext   = {{PADDR_W{1'b0}}, w_join_frame, r_off};
        w_join       = w_join_ext[PADDR_W-1:0];
        w_rank_ext   = (WAY_BITS+RANK_W+1)'(w_lru_rank) + 1'b1;
    end

    // tag/frame store, one read or write a cycle
    always_ff @(posedge i_clk) begin
        if (w_lru_req.fill) begin
            mem_tag[{w_set, w_victim}]   <= w_tag;
            mem_frame[{w_set, w_victim}] <= r_walk_frame;
        end
        if (r_state == S_RD) begin
            r_tag_q   <= mem_tag[{w_set, r_way}];
            r_frame_q <= mem_frame[{w_set, r_way}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_reply     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    if (r_sweep == SET_BITS'(NUM_SETS - 1)) begin
                        r_sweep <= '0;
                        r_state <= r_reply ? S_OUT : S_IDLE;
                    end else begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd        <= i_in.cmd;
                        r_off        <= i_in.vaddr[OFFSET_BITS-1:0];
                        r_walk_fault <= i_in.walk_fault;
                        r_walk_frame <= i_in.walk_frame;
                        r_hit        <= 1'b0;
                        r_res_hit    <= 1'b0;
                        r_res_fault  <= 1'b0;
                        r_res_paddr  <= '0;
                        r_res_rank   <= '0;
                        case (i_in.cmd)
                            CMD_XLATE, CMD_PEEK: r_state <= S_DIV;
                            CMD_CLEAR: begin
                                r_reply <= 1'b1;
                                r_state <= S_SWEEP;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_way   <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_match) begin
                        r_hit       <= 1'b1;
                        r_hit_frame <= r_frame_q;
                        r_state     <= S_UPD;
                    end else if (r_way == WAY_BITS'(NUM_WAYS - 1)) begin
                        r_state <= S_UPD;
                    end else begin
                        r_way   <= r_way + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_UPD: begin
                    case (r_cmd)
                        CMD_XLATE: begin
                            r_res_hit <= r_hit;
                            if (!r_hit && r_walk_fault) begin
                                r_res_fault <= 1'b1;
                                r_res_paddr <= '1;
                            end else begin
                                r_res_paddr <= w_join;
                            end
                        end
                        CMD_PEEK: begin
                            if (r_hit) begin
                                r_res_hit  <= 1'b1;
                                r_res_rank <= w_rank_ext[RANK_W-1:0];
                            end
                        end
                        default: r_res_hit <= 1'b0;
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_res_hit;
                        r_out_fault <= r_res_fault;
                        r_out_paddr <= r_res_paddr;
                        r_out_rank  <= r_res_rank;
                        r_reply     <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.hit   = r_out_hit;
    assign o_out.fault = r_out_fault;
    assign o_out.paddr = r_out_paddr;
    assign o_out.rank  = r_out_rank;

    `STLRU_ASSERT_IMPL(a_done_in_div, w_div_done, r_state == S_DIV, "divider done outside wait")
    `STLRU_ASSERT_IMPL(a_cmp_after_rd, r_state == S_CMP, $past(r_state) == S_RD, "compare without read")
    `STLRU_ASSERT_NEXT(a_sweep_holds, (r_state == S_SWEEP) && (r_sweep != SET_BITS'(NUM_SETS - 1)), r_state == S_SWEEP, "sweep cut short")
    `STLRU_ASSERT_IMPL(a_fault_result, o_out.valid && o_out.fault, !o_out.hit && (o_out.paddr == '1) && (o_out.rank == '0), "bad fault result")
    `STLRU_ASSERT_IMPL(a_rank_on_hit, o_out.valid && (o_out.rank != '0), o_out.hit && !o_out.fault, "rank without hit")

endmodule

### tb/sv/set_assoc_tlb_lru_test.sv
`timescale 1ns / 100ps

import stlru_pkg::*;

typedef struct packed {
    logic               hit;
    logic               fault;
    logic [PADDR_W-1:0] paddr;
    logic [RANK_W-1:0]  rank;
} xlate_result_t;

class tlb_scoreboard;
    localparam int OFFSET_BITS = 12;
    localparam int NUM_SETS    = 16;
    localparam int NUM_WAYS    = 4;
    localparam int SET_W       = $clog2(NUM_SETS);
    localparam int TAG_W       = VADDR_W - OFFSET_BITS - SET_W;

    bit                 way_valid [NUM_SETS][NUM_WAYS];
    logic [TAG_W-1:0]   way_tag   [NUM_SETS][NUM_WAYS];
    logic [FRAME_W-1:0] way_frame [NUM_SETS][NUM_WAYS];
    int                 way_rank  [NUM_SETS][NUM_WAYS];
    xlate_result_t      expected_q[$];

    int mismatches;
    int results_seen;
    int n_xlate, n_hit, n_fault, n_evict, n_peek, n_peek_hit, n_clear, n_unused;

    function void flush_entries();
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                way_valid[s][w] = 1'b0;
                way_rank[s][w]  = w;
            end
        end
    endfunction

    // Move a way to the front; ways that were more recent slide back by one.
    function void make_recent(int s, int w);
        int old;
        old = way_rank[s][w];
        for (int v = 0; v < NUM_WAYS; v++) begin
            if (way_rank[s][v] < old) way_rank[s][v]++;
        end
        way_rank[s][w] = 0;
    endfunction

    function int find_way(int s, logic [TAG_W-1:0] tag);
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (way_valid[s][w] && way_tag[s][w] == tag) return w;
        end
        return NUM_WAYS;
    endfunction

    // Fill empty ways first, otherwise evict the least recent one.
    function int choose_victim(int s);
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!way_valid[s][w]) return w;
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (way_rank[s][w] == NUM_WAYS - 1) return w;
        end
        return 0;
    endfunction

    function logic [PADDR_W-1:0] join_frame(logic [FRAME_W-1:0] frame,
                                            logic [OFFSET_BITS-1:0] off);
        return (PADDR_W'(frame) << OFFSET_BITS) | PADDR_W'(off);
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [VADDR_W-1:0] va,
                               logic wfault, logic [FRAME_W-1:0] wframe);
        xlate_result_t          r;
        logic [OFFSET_BITS-1:0] off;
        logic [TAG_W-1:0]       tag;
        int                     s;
        int                     w;
        off = va[OFFSET_BITS-1:0];
        s   = int'(va[OFFSET_BITS +: SET_W]);
        tag = va[VADDR_W-1 -: TAG_W];
        r   = '0;
        case (cmd)
            CMD_XLATE: begin
                n_xlate++;
                w = find_way(s, tag);
                if (w < NUM_WAYS) begin
                    n_hit++;
                    make_recent(s, w);
                    r.hit   = 1'b1;
                    r.paddr = join_frame(way_frame[s][w], off);
                end else if (wfault) begin
                    n_fault++;
                    r.fault = 1'b1;
                    r.paddr = '1;
                end else begin
                    w = choose_victim(s);
                    if (way_valid[s][w]) n_evict++;
                    way_valid[s][w] = 1'b1;
                    way_tag[s][w]   = tag;
                    way_frame[s][w] = wframe;
                    make_recent(s, w);
                    r.paddr = join_frame(wframe, off);
                end
            end
            CMD_PEEK: begin
                n_peek++;
                w = find_way(s, tag);
                if (w < NUM_WAYS) begin
                    n_peek_hit++;
                    r.hit  = 1'b1;
                    r.rank = RANK_W'(way_rank[s][w] + 1);
                end
            end
            CMD_CLEAR: begin
                n_clear++;
                flush_entries();
            end
            default: n_unused++;
        endcase
        expected_q.push_back(r);
    endfunction

    function void compare_field(string field, logic [PADDR_W-1:0] want,
                                logic [PADDR_W-1:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s mismatch on result %0d: expected 0x%0h, got 0x%0h",
                         $time, field, results_seen, want, seen);
        end
    endfunction

    function void check_result(xlate_result_t got);
        xlate_result_t want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result with nothing outstanding: hit %0b fault %0b paddr 0x%0h rank %0d",
                         $time, got.hit, got.fault, got.paddr, got.rank);
            return;
        end
        want = expected_q.pop_front();
        results_seen++;
        compare_field("hit", PADDR_W'(want.hit), PADDR_W'(got.hit));
        compare_field("fault", PADDR_W'(want.fault), PADDR_W'(got.fault));
        compare_field("paddr", want.paddr, got.paddr);
        compare_field("rank", PADDR_W'(want.rank), PADDR_W'(got.rank));
    endfunction
endclass

module set_assoc_tlb_lru_test;
    localparam int OFFSET_BITS  = 12;
    localparam int NUM_SETS     = 16;
    localparam int NUM_WAYS     = 4;
    localparam int VA_BITS      = 48;
    localparam int SET_W        = $clog2(NUM_SETS);
    localparam int TAG_W        = VADDR_W - OFFSET_BITS - SET_W;
    localparam int RANDOM_ITEMS = 1030;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 64;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        ALWAYS_READY,
        COIN_FLIP,
        MOSTLY_STALLED,
        ALTERNATE
    } stall_pattern_e;

    logic i_clk;
    logic i_rst_n;

    stlru_in_if  req_if();
    stlru_out_if rsp_if();

    set_assoc_tlb_lru #(
        .OFFSET_BITS (OFFSET_BITS),
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .VA_BITS     (VA_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    tlb_scoreboard    sb;
    int               burst_left;
    int               idle_cycles;
    logic [TAG_W-1:0] tag_pool [6];
    logic [SET_W-1:0] hot_sets [3];

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Check the outgoing result before noting the incoming item of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result({rsp_if.hit, rsp_if.fault, rsp_if.paddr, rsp_if.rank});
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.cmd, req_if.vaddr, req_if.walk_fault,
                                req_if.walk_frame);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, sb.expected_q.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: drive ready with a randomly chosen stall pattern, picking a new one when the current one runs out.
    initial begin
        stall_pattern_e pattern;
        int             pattern_left;
        pattern      = ALWAYS_READY;
        pattern_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pattern_left == 0) begin
                pattern      = stall_pattern_e'($urandom_range(0, 3));
                pattern_left = $urandom_range(40, 400);
            end else begin
                pattern_left--;
            end
            case (pattern)
                ALWAYS_READY:   rsp_if.ready <= 1'b1;
                COIN_FLIP:      rsp_if.ready <= 1'($urandom_range(0, 1));
                MOSTLY_STALLED: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                default:        rsp_if.ready <= ~rsp_if.ready;
            endcase
        end
    end

    function automatic logic [VADDR_W-1:0] vaddr_of(logic [SET_W-1:0] set_idx,
                                                    logic [TAG_W-1:0] tag,
                                                    logic [OFFSET_BITS-1:0] off);
        return {tag, set_idx, off};
    endfunction

    function automatic logic [FRAME_W-1:0] any_frame();
        return FRAME_W'({$urandom(), $urandom()});
    endfunction

    // End the current burst with a gap, or keep valid high for the next item.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic push_request(logic [CMD_W-1:0] cmd, logic [VADDR_W-1:0] va,
                                logic wfault, logic [FRAME_W-1:0] wframe);
        pace_sender();
        req_if.valid      <= 1'b1;
        req_if.cmd        <= cmd;
        req_if.vaddr      <= va;
        req_if.walk_fault <= wfault;
        req_if.walk_frame <= wframe;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic wait_until_drained();
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [CMD_W-1:0]   cmd;
        logic [VADDR_W-1:0] va;
        logic [SET_W-1:0]   set_idx;
        int                 pick;

        sb = new();
        sb.flush_entries();
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int k = 2; k < 6; k++) tag_pool[k] = TAG_W'($urandom());
        hot_sets[0] = '0;
        hot_sets[1] = '1;
        hot_sets[2] = SET_W'($urandom_range(1, NUM_SETS - 2));
        burst_left = 0;

        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.cmd        <= CMD_XLATE;
        req_if.vaddr      <= '0;
        req_if.walk_fault <= 1'b0;
        req_if.walk_frame <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty buffer, first fill, hit with walk fields to ignore, rank of a lone entry.
        push_request(CMD_PEEK, vaddr_of(0, 0, 0), 1'b0, '0);
        push_request(CMD_XLATE, vaddr_of(0, 0, 0), 1'b0, '0);
        push_request(CMD_XLATE, vaddr_of(0, 0, '1), 1'b1, '1);
        push_request(CMD_PEEK, vaddr_of(0, 0, 12'h5a5), 1'b0, '0);
        // All-ones address and frame, then a walk fault that must leave the set alone.
        push_request(CMD_XLATE, '1, 1'b0, '1);
        push_request(CMD_XLATE, vaddr_of('1, 0, '1), 1'b1, any_frame());
        push_request(CMD_PEEK, vaddr_of('1, 0, 0), 1'b0, '0);
        // Fill one set, reorder it, then force an eviction of the least recent way.
        for (int t = 1; t <= NUM_WAYS; t++)
            push_request(CMD_XLATE, vaddr_of(3, t, OFFSET_BITS'(t)), 1'b0, any_frame());
        push_request(CMD_PEEK, vaddr_of(3, 1, 0), 1'b0, '0);
        push_request(CMD_PEEK, vaddr_of(3, NUM_WAYS, 0), 1'b0, '0);
        push_request(CMD_XLATE, vaddr_of(3, 2, 12'h0f0), 1'b1, any_frame());
        push_request(CMD_XLATE, vaddr_of(3, 5, 12'h00f), 1'b0, any_frame());
        push_request(CMD_PEEK, vaddr_of(3, 1, 0), 1'b0, '0);
        push_request(CMD_PEEK, vaddr_of(3, 3, 0), 1'b0, '0);
        push_request(CMD_PEEK, vaddr_of(3, 2, 0), 1'b0, '0);
        // Unused code, clear, and lookups after the clear.
        push_request(CMD_UNUSED, '1, 1'b1, '1);
        push_request(CMD_CLEAR, '1, 1'b1, '1);
        push_request(CMD_PEEK, '1, 1'b0, '0);
        push_request(CMD_XLATE, vaddr_of(3, 5, 12'h800), 1'b0, any_frame());
        push_request(CMD_PEEK, vaddr_of(0, 0, 0), 1'b0, '0);

        // Hold the sender until every outstanding result is back.
        req_if.valid <= 1'b0;
        wait_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2)       cmd = CMD_CLEAR;
            else if (pick < 4)  cmd = CMD_UNUSED;
            else if (pick < 32) cmd = CMD_PEEK;
            else                cmd = CMD_XLATE;
            if ($urandom_range(0, 9) == 0) begin
                va = VADDR_W'({$urandom(), $urandom()});
            end else begin
                set_idx = $urandom_range(0, 1) ? hot_sets[$urandom_range(0, 2)]
                                               : SET_W'($urandom_range(0, NUM_SETS - 1));
                va = vaddr_of(set_idx, tag_pool[$urandom_range(0, 5)],
                              OFFSET_BITS'($urandom()));
            end
            push_request(cmd, va, ($urandom_range(0, 7) == 0), any_frame());
        end
        req_if.valid <= 1'b0;

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d translates (%0d hits, %0d walk faults, %0d evictions), %0d peeks (%0d found), %0d clears, %0d unused codes",
                 sb.n_xlate, sb.n_hit, sb.n_fault, sb.n_evict, sb.n_peek, sb.n_peek_hit,
                 sb.n_clear, sb.n_unused);
        $display("%0d results checked, %0d mismatches, %0d results never returned",
                 sb.results_seen, sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/stlru_pkg.sv
rtl/stlru_in_if.sv
rtl/stlru_out_if.sv
rtl/stlru_div.sv
rtl/stlru_lru.sv
rtl/set_assoc_tlb_lru.sv
tb/sv/set_assoc_tlb_lru_test.sv
